[hdl/ctc_pkg.sv]
// Shared constants and types for the CTC greedy decoder.
package ctc_pkg;

  localparam int MAX_STEPS   = 256;
  localparam int CLASS_BITS  = 15;
  localparam int SCORE_W     = 16;
  localparam int IDX_W       = 15;
  localparam int CNT_W       = $clog2(MAX_STEPS + 1);
  localparam int SUM_W       = SCORE_W + CNT_W;
  localparam int QUOT_W      = SUM_W - 1;
  localparam int DIV_CNT_W   = $clog2(QUOT_W);
  localparam int FIFO_DEPTH  = 4;
  localparam int FIFO_PTR_W  = $clog2(FIFO_DEPTH);
  localparam int IN_DATA_W   = 16;
  localparam int OUT_DATA_W  = 40;

  localparam logic [CLASS_BITS-1:0] CLASS_MAX = '1;

  typedef struct packed {
    logic                      has_char;
    logic                      seq_end;
    logic [IDX_W-1:0]          char_index;
    logic signed [SCORE_W-1:0] score;
  } step_event_t;

  typedef enum logic [3:0] {
    ST_POP  = 4'b0001,
    ST_CHAR = 4'b0010,
    ST_DIV  = 4'b0100,
    ST_SUM  = 4'b1000
  } back_state_t;

  typedef enum logic {
    KIND_CHAR    = 1'b0,
    KIND_SUMMARY = 1'b1
  } result_kind_t;

endpackage

[hdl/ctc_front.sv]
// Front end: per-step argmax, blank and repeat removal, dictionary check.
module ctc_front (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_wen,
  input  logic [ctc_pkg::IDX_W-1:0]          cfg_wdata,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic signed [ctc_pkg::SCORE_W-1:0] score,
  input  logic                               last_class,
  input  logic                               last_step,
  input  logic                               queue_full,
  output logic                               push,
  output ctc_pkg::step_event_t               push_event
);
  import ctc_pkg::*;

  logic [IDX_W-1:0]          dict_entries;
  logic [CLASS_BITS-1:0]     class_position;
  logic signed [SCORE_W-1:0] best_score;
  logic [CLASS_BITS-1:0]     best_class;
  logic [CLASS_BITS-1:0]     previous_winner;

  logic                      accept;
  logic                      better;
  logic signed [SCORE_W-1:0] best_score_next;
  logic [CLASS_BITS-1:0]     best_class_next;
  logic [IDX_W-1:0]          cand_index;
  logic                      emit;

  assign in_ready = !queue_full;
  assign accept   = in_valid && in_ready;

  always_comb begin
    better          = (class_position == '0) || (score > best_score);
    best_score_next = better ? score : best_score;
    best_class_next = better ? class_position : best_class;
    cand_index      = IDX_W'(best_class_next - CLASS_BITS'(1));
    emit            = (best_class_next != '0) && (best_class_next != previous_winner) &&
                      (cand_index < dict_entries);
  end

  assign push                  = accept && last_class && (emit || last_step);
  assign push_event.has_char   = emit;
  assign push_event.seq_end    = last_step;
  assign push_event.char_index = cand_index;
  assign push_event.score      = best_score_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      dict_entries    <= '0;
      class_position  <= '0;
      best_score      <= '0;
      best_class      <= '0;
      previous_winner <= '0;
    end else begin
      if (cfg_wen) begin
        dict_entries <= cfg_wdata;
      end
      if (accept) begin
        best_score <= best_score_next;
        best_class <= best_class_next;
        if (!last_class) begin
          if (class_position < CLASS_MAX) begin
            class_position <= class_position + CLASS_BITS'(1);
          end
        end else begin
          class_position  <= '0;
          previous_winner <= last_step ? '0 : best_class_next;
        end
      end
    end
  end

endmodule

[hdl/ctc_queue.sv]
// Short event queue between the front and back ends.
module ctc_queue (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  input  ctc_pkg::step_event_t push_event,
  output logic                 full,
  input  logic                 pop,
  output logic                 empty,
  output ctc_pkg::step_event_t head
);
  import ctc_pkg::*;

  step_event_t               entries [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0]     wr_ptr;
  logic [FIFO_PTR_W-1:0]     rd_ptr;
  logic [FIFO_PTR_W:0]       fill;
  logic                      do_push;
  logic                      do_pop;

  assign full    = (fill == (FIFO_PTR_W + 1)'(FIFO_DEPTH));
  assign empty   = (fill == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign head    = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_event;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + FIFO_PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + FIFO_PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        fill <= fill + (FIFO_PTR_W + 1)'(1);
      end else if (do_pop && !do_push) begin
        fill <= fill - (FIFO_PTR_W + 1)'(1);
      end
    end
  end

endmodule

[hdl/ctc_back.sv]
// Back end: character count and score sum, mean by serial division, result register.
module ctc_back (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                empty,
  input  ctc_pkg::step_event_t                head,
  output logic                                pop,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic                                out_kind,
  output logic [ctc_pkg::IDX_W-1:0]           out_index,
  output logic signed [ctc_pkg::SCORE_W-1:0]  out_mean,
  output logic [ctc_pkg::CNT_W-1:0]           out_total,
  output logic                                out_last
);
  import ctc_pkg::*;

  back_state_t               state;
  logic [CNT_W-1:0]          count;
  logic signed [SUM_W-1:0]   score_sum;
  logic                      pending_end;

  logic [QUOT_W-1:0]         quot;
  logic [CNT_W:0]            rem;
  logic [DIV_CNT_W-1:0]      div_cnt;
  logic                      div_neg;

  logic [CNT_W:0]            rem_sh;
  logic                      ge;
  logic [CNT_W:0]            rem_next;
  logic [QUOT_W-1:0]         quot_next;
  logic [QUOT_W-1:0]         quot_signed;
  logic [SUM_W-1:0]          sum_mag;
  logic [CNT_W-1:0]          count_inc;
  logic                      can_count;

  assign out_valid = (state == ST_CHAR) || (state == ST_SUM);
  assign pop       = (state == ST_POP) && !empty;
  assign can_count = (count < CNT_W'(MAX_STEPS));
  assign count_inc = can_count ? count + CNT_W'(1) : count;

  always_comb begin
    rem_sh      = {rem[CNT_W-1:0], quot[QUOT_W-1]};
    ge          = (rem_sh >= {1'b0, count});
    rem_next    = ge ? rem_sh - {1'b0, count} : rem_sh;
    quot_next   = {quot[QUOT_W-2:0], ge};
    quot_signed = div_neg ? QUOT_W'(-quot_next) : quot_next;
    sum_mag     = score_sum[SUM_W-1] ? SUM_W'(-score_sum) : SUM_W'(score_sum);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_POP;
      count       <= '0;
      score_sum   <= '0;
      pending_end <= 1'b0;
      div_cnt     <= '0;
    end else begin
      unique case (state)
        ST_POP: begin
          if (!empty) begin
            pending_end <= head.seq_end;
            if (head.has_char) begin
              if (can_count) begin
                count     <= count_inc;
                score_sum <= score_sum + SUM_W'(head.score);
              end
              out_kind  <= KIND_CHAR;
              out_index <= head.char_index;
              out_mean  <= head.score;
              out_total <= count_inc;
              out_last  <= 1'b0;
              state     <= ST_CHAR;
            end else begin
              quot    <= sum_mag[QUOT_W-1:0];
              rem     <= '0;
              div_cnt <= '0;
              div_neg <= score_sum[SUM_W-1];
              state   <= ST_DIV;
            end
          end
        end
        ST_CHAR: begin
          if (out_ready) begin
            if (pending_end) begin
              quot    <= sum_mag[QUOT_W-1:0];
              rem     <= '0;
              div_cnt <= '0;
              div_neg <= score_sum[SUM_W-1];
              state   <= ST_DIV;
            end else begin
              state <= ST_POP;
            end
          end
        end
        ST_DIV: begin
          quot    <= quot_next;
          rem     <= rem_next;
          div_cnt <= div_cnt + DIV_CNT_W'(1);
          if (div_cnt == DIV_CNT_W'(QUOT_W - 1)) begin
            out_kind  <= KIND_SUMMARY;
            out_index <= '0;
            out_mean  <= (count == '0) ? '0 : quot_signed[SCORE_W-1:0];
            out_total <= count;
            out_last  <= 1'b1;
            state     <= ST_SUM;
          end
        end
        ST_SUM: begin
          if (out_ready) begin
            count     <= '0;
            score_sum <= '0;
            state     <= ST_POP;
          end
        end
        default: begin
          state <= ST_POP;
        end
      endcase
    end
  end

`ifndef SYNTH
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(MAX_STEPS))
    else $error("character count above its limit");

  a_sum_after_div: assert property (@(posedge clk) disable iff (rst)
    $rose(state == ST_SUM) |-> $past(state == ST_DIV))
    else $error("summary presented without a completed division");

  a_empty_mean: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SUM) && (count == '0) |-> (out_mean == '0))
    else $error("summary of an empty sequence carries a nonzero mean");

  a_kind_last: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_last == (out_kind == KIND_SUMMARY)))
    else $error("last flag disagrees with result kind");
`endif

endmodule

[hdl/ctc_greedy_decoder_core.sv]
// CTC greedy decoder top level: front end, event queue and back end.
//
// Class scores enter one beat at a time on the s_ channel: tdata carries the
// Q5.10 score, tlast marks the final class of a time step and tuser marks the
// final step of a sequence. The front end takes one beat per cycle whenever
// the event queue has room. At each step end a character beat is queued when the
// winner is not blank, not a repeat and inside the dictionary; the last step also
// queues a summary. The back end pops a character from the head of the queue and
// shows it in the cycle after the pop. A summary needs a serial division of 24
// quotient bits, one quotient bit per cycle, before it appears. Results leave on
// the m_ channel from an output register; while the receiver stalls, the queue of
// four events keeps the front end running until it fills, after which s_tready
// drops. The user must write the dictionary size through cfg_wen and cfg_wdata
// while the block is idle; the block does not enforce this. Synchronous reset
// clears the queue, the counters and the dictionary size; the block accepts
// beats as soon as reset is released.
module ctc_greedy_decoder_core (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_wen,
  input  logic [ctc_pkg::IDX_W-1:0]         cfg_wdata,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  input  logic [ctc_pkg::IN_DATA_W-1:0]     s_tdata,   // score
  input  logic                              s_tlast,
  input  logic                              s_tuser,   // last_step
  output logic                              m_tvalid,
  input  logic                              m_tready,
  output logic [ctc_pkg::OUT_DATA_W-1:0]    m_tdata,   // char_index, mean_score, char_total
  output logic                              m_tlast,
  output logic                              m_tuser    // kind
);
  import ctc_pkg::*;

  logic                      push;
  step_event_t               push_event;
  logic                      full;
  logic                      pop;
  logic                      empty;
  step_event_t               head;
  logic [IDX_W-1:0]          out_index;
  logic signed [SCORE_W-1:0] out_mean;
  logic [CNT_W-1:0]          out_total;

  ctc_front u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg_wen    (cfg_wen),
    .cfg_wdata  (cfg_wdata),
    .in_valid   (s_tvalid),
    .in_ready   (s_tready),
    .score      (s_tdata[SCORE_W-1:0]),
    .last_class (s_tlast),
    .last_step  (s_tuser),
    .queue_full (full),
    .push       (push),
    .push_event (push_event)
  );

  ctc_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_event (push_event),
    .full       (full),
    .pop        (pop),
    .empty      (empty),
    .head       (head)
  );

  ctc_back u_back (
    .clk       (clk),
    .rst       (rst),
    .empty     (empty),
    .head      (head),
    .pop       (pop),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_kind  (m_tuser),
    .out_index (out_index),
    .out_mean  (out_mean),
    .out_total (out_total),
    .out_last  (m_tlast)
  );

  assign m_tdata = {out_total, out_mean, out_index};

endmodule
